// ----- src/assert_macros.svh -----
// assertion helpers for the rtl files, included by dpfr_datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, also during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/dpfr_pkg.sv -----
// ----------------------------------------------------------------------------
// dpfr_pkg
// Shared constants and controller/datapath link types for the frame replacer.
// ----------------------------------------------------------------------------
`default_nettype none

package dpfr_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int FRAME_W    = 4;
    localparam int JOB_W      = 3;
    localparam int PAGE_W     = 4;
    localparam int OWNER_W    = JOB_W + PAGE_W;
    localparam int AGE_W      = 8;
    localparam int COUNT_W    = 32;
    localparam int FCOUNT_W   = 5;
    localparam int CFG_DATA_W = 5;

    localparam logic [AGE_W-1:0]    AGE_MSB   = 8'h80;
    localparam logic [COUNT_W-1:0]  SAT_COUNT = 32'hFFFF_FFFF;
    localparam logic [FCOUNT_W-1:0] FRAMES_MAX_CODE = 5'd16;

    // register indexes of the configuration port
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_FRAMES = 1'b1;

    // policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    // command codes
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- src/dpfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// dpfr_ctrl
// Sequencer: accept a transaction, walk the frame table for an access, commit the result.
// ----------------------------------------------------------------------------
`default_nettype none

module dpfr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                command,
    output logic                     in_ready,
    output dpfr_pkg::dp_cmd_t        cmd,
    input  wire dpfr_pkg::dp_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    if (command == dpfr_pkg::CMD_CLEAR)
                        state_next = ST_COMMIT;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ----- src/dpfr_datapath.sv -----
// ----------------------------------------------------------------------------
// dpfr_datapath
// Frame table, ages, load-order list, counters, frame walk and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dpfr_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dpfr_pkg::dp_cmd_t             cmd,
    output dpfr_pkg::dp_status_t               status,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [dpfr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          command,
    input  wire logic [dpfr_pkg::JOB_W-1:0]    job_id,
    input  wire logic [dpfr_pkg::PAGE_W-1:0]   page_number,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               hit,
    output logic [dpfr_pkg::FRAME_W-1:0]       frame,
    output logic                               evicted,
    output logic [dpfr_pkg::JOB_W-1:0]         evicted_job,
    output logic [dpfr_pkg::PAGE_W-1:0]        evicted_page,
    output logic [dpfr_pkg::COUNT_W-1:0]       hit_total,
    output logic [dpfr_pkg::COUNT_W-1:0]       fault_total
);

    localparam int NF = dpfr_pkg::MAX_FRAMES;
    localparam int FW = dpfr_pkg::FRAME_W;
    localparam int AW = dpfr_pkg::AGE_W;
    localparam int OW = dpfr_pkg::OWNER_W;
    localparam int CW = dpfr_pkg::COUNT_W;
    localparam int NW = dpfr_pkg::FCOUNT_W;

    // configuration
    logic          policy_reg;
    logic [NW-1:0] frames_reg;
    logic [NW-1:0] limit;

    // frame table
    logic [NF-1:0] busy_reg;
    logic [OW-1:0] owner_reg [NF];
    logic [AW-1:0] age_reg   [NF];
    logic [FW-1:0] order_reg [NF];
    logic [FW-1:0] head_reg;
    logic [NW-1:0] count_reg;
    logic [CW-1:0] hits_reg;
    logic [CW-1:0] faults_reg;

    // current transaction and walk results
    logic          clr_reg;
    logic [OW-1:0] key_reg;
    logic [FW-1:0] idx_reg;
    logic          hit_f_reg;
    logic [FW-1:0] hit_frame_reg;
    logic          free_f_reg;
    logic [FW-1:0] free_frame_reg;
    logic [AW:0]   best_age_reg;
    logic [FW-1:0] best_frame_reg;

    // result register
    logic          out_valid_reg;
    logic          hit_out_reg;
    logic [FW-1:0] frame_out_reg;
    logic          ev_out_reg;
    logic [OW-1:0] ev_owner_reg;
    logic [CW-1:0] hit_tot_reg;
    logic [CW-1:0] fault_tot_reg;

    // commit decisions
    logic          in_lim;
    logic [FW-1:0] sel_frame;
    logic          sel_busy;
    logic [FW-1:0] popped;
    logic [FW-1:0] head_next;
    logic [NW-1:0] count_next;
    logic [NW-1:0] count_pop;
    logic          push_en;
    logic [FW-1:0] push_slot;
    logic [CW-1:0] hits_next;
    logic [CW-1:0] faults_next;
    logic          do_access;

    // usable frame count, clamped to 1..MAX_FRAMES
    always_comb
    begin
        if (frames_reg == '0)
            limit = NW'(1);
        else if (frames_reg > dpfr_pkg::FRAMES_MAX_CODE)
            limit = dpfr_pkg::FRAMES_MAX_CODE;
        else
            limit = frames_reg;
    end

    assign in_lim = ({1'b0, idx_reg} < limit);
    assign status.scan_last = (idx_reg == FW'(NF - 1));
    assign status.out_free  = !out_valid_reg || out_ready;
    assign do_access = cmd.commit && !clr_reg;

    // victim selection and load-order list update
    always_comb
    begin
        popped    = (count_reg == '0) ? '0 : order_reg[head_reg];
        count_pop = (count_reg == '0) ? '0 : count_reg - NW'(1);
        head_next = head_reg;
        count_next = count_reg;
        push_en   = 1'b0;
        push_slot = head_reg + count_reg[FW-1:0];
        sel_frame = free_frame_reg;
        if (free_f_reg)
        begin
            if (count_reg < dpfr_pkg::FRAMES_MAX_CODE)
            begin
                push_en    = 1'b1;
                count_next = count_reg + NW'(1);
            end
        end
        else if (policy_reg == dpfr_pkg::POLICY_FIFO)
        begin
            sel_frame  = popped;
            head_next  = (count_reg == '0) ? head_reg : head_reg + FW'(1);
            push_en    = 1'b1;
            push_slot  = head_next + count_pop[FW-1:0];
            count_next = count_pop + NW'(1);
        end
        else
        begin
            sel_frame = best_frame_reg;
        end
        sel_busy = busy_reg[sel_frame];
        hits_next   = (hits_reg == dpfr_pkg::SAT_COUNT) ? hits_reg : hits_reg + CW'(1);
        faults_next = (faults_reg == dpfr_pkg::SAT_COUNT) ? faults_reg : faults_reg + CW'(1);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= dpfr_pkg::POLICY_FIFO;
            frames_reg <= dpfr_pkg::FRAMES_MAX_CODE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dpfr_pkg::REG_POLICY: policy_reg <= cfg_data[0];
                dpfr_pkg::REG_FRAMES: frames_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control state of the tables, counters and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            hits_reg      <= '0;
            faults_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                if (clr_reg)
                begin
                    busy_reg   <= '0;
                    head_reg   <= '0;
                    count_reg  <= '0;
                    hits_reg   <= '0;
                    faults_reg <= '0;
                end
                else if (hit_f_reg)
                    hits_reg <= hits_next;
                else
                begin
                    faults_reg          <= faults_next;
                    busy_reg[sel_frame] <= 1'b1;
                    head_reg            <= head_next;
                    count_reg           <= count_next;
                end
            end
        end
    end

    // frame payload, ages and load-order list
    always_ff @(posedge clk)
    begin
        if (cmd.start && command != dpfr_pkg::CMD_CLEAR)
        begin
            for (int f = 0; f < NF; f++)
                if (busy_reg[f])
                    age_reg[f] <= age_reg[f] >> 1;
        end
        if (do_access)
        begin
            if (hit_f_reg)
                age_reg[hit_frame_reg] <= age_reg[hit_frame_reg] | dpfr_pkg::AGE_MSB;
            else
            begin
                age_reg[sel_frame]   <= dpfr_pkg::AGE_MSB;
                owner_reg[sel_frame] <= key_reg;
                if (push_en)
                    order_reg[push_slot] <= sel_frame;
            end
        end
    end

    // transaction latch and frame walk
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            clr_reg        <= command;
            key_reg        <= {job_id, page_number};
            idx_reg        <= '0;
            hit_f_reg      <= 1'b0;
            hit_frame_reg  <= '0;
            free_f_reg     <= 1'b0;
            free_frame_reg <= '0;
            best_age_reg   <= {1'b1, {AW{1'b0}}};
            best_frame_reg <= '0;
        end
        else if (cmd.scan)
        begin
            idx_reg <= idx_reg + FW'(1);
            if (busy_reg[idx_reg] && owner_reg[idx_reg] == key_reg)
            begin
                hit_f_reg     <= 1'b1;
                hit_frame_reg <= idx_reg;
            end
            if (!busy_reg[idx_reg] && in_lim && !free_f_reg)
            begin
                free_f_reg     <= 1'b1;
                free_frame_reg <= idx_reg;
            end
            if (busy_reg[idx_reg] && in_lim && {1'b0, age_reg[idx_reg]} < best_age_reg)
            begin
                best_age_reg   <= {1'b0, age_reg[idx_reg]};
                best_frame_reg <= idx_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (clr_reg)
            begin
                hit_out_reg   <= 1'b0;
                frame_out_reg <= '0;
                ev_out_reg    <= 1'b0;
                ev_owner_reg  <= '0;
                hit_tot_reg   <= '0;
                fault_tot_reg <= '0;
            end
            else if (hit_f_reg)
            begin
                hit_out_reg   <= 1'b1;
                frame_out_reg <= hit_frame_reg;
                ev_out_reg    <= 1'b0;
                ev_owner_reg  <= '0;
                hit_tot_reg   <= hits_next;
                fault_tot_reg <= faults_reg;
            end
            else
            begin
                hit_out_reg   <= 1'b0;
                frame_out_reg <= sel_frame;
                ev_out_reg    <= sel_busy;
                ev_owner_reg  <= sel_busy ? owner_reg[sel_frame] : '0;
                hit_tot_reg   <= hits_reg;
                fault_tot_reg <= faults_next;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_out_reg;
    assign frame        = frame_out_reg;
    assign evicted      = ev_out_reg;
    assign evicted_job  = ev_owner_reg[OW-1:dpfr_pkg::PAGE_W];
    assign evicted_page = ev_owner_reg[dpfr_pkg::PAGE_W-1:0];
    assign hit_total    = hit_tot_reg;
    assign fault_total  = fault_tot_reg;

    // a result is never committed over one still waiting
    `ASSERT_CLK(a_commit_free, cmd.commit |-> (!out_valid_reg || out_ready), "commit over full result")
    // the load-order list never holds more than MAX_FRAMES entries
    `ASSERT_CLK(a_count_max, count_reg <= dpfr_pkg::FRAMES_MAX_CODE, "load-order list overflow")
    // a commit always presents a result on the next cycle
    `ASSERT_CLK(a_commit_out, cmd.commit |=> out_valid_reg, "commit lost its result")
    // start and commit never coincide
    `ASSERT_ALWAYS(a_cmd_excl, !(cmd.start && cmd.commit), "start and commit together")

endmodule

`default_nettype wire

// ----- src/demand_paging_frame_replacer.sv -----
// ----------------------------------------------------------------------------
// demand_paging_frame_replacer
// Page access resolver with FIFO or aging-LRU frame replacement.
//
//   channel  signals                                  direction
//   in       in_valid/in_ready, command, job_id,      in
//            page_number
//   out      out_valid/out_ready, hit, frame,         out
//            evicted, evicted_job, evicted_page,
//            hit_total, fault_total
//   cfg      cfg_we, cfg_index, cfg_data               in (write only)
//
// An access runs accept, a walk of the frame table
// (hit match, lowest free frame and smallest age, one frame per cycle),
// then commit. A clear transaction goes from accept straight to commit.
// Commit waits while the previous result is still unaccepted. Reset is
// asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module demand_paging_frame_replacer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_index,
    input  wire logic [dpfr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            command,
    input  wire logic [dpfr_pkg::JOB_W-1:0]      job_id,
    input  wire logic [dpfr_pkg::PAGE_W-1:0]     page_number,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 hit,
    output logic [dpfr_pkg::FRAME_W-1:0]         frame,
    output logic                                 evicted,
    output logic [dpfr_pkg::JOB_W-1:0]           evicted_job,
    output logic [dpfr_pkg::PAGE_W-1:0]          evicted_page,
    output logic [dpfr_pkg::COUNT_W-1:0]         hit_total,
    output logic [dpfr_pkg::COUNT_W-1:0]         fault_total
);

    dpfr_pkg::dp_cmd_t    cmd;
    dpfr_pkg::dp_status_t status;

    // sequencer
    dpfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    // tables and result
    dpfr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .command      (command),
        .job_id       (job_id),
        .page_number  (page_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .frame        (frame),
        .evicted      (evicted),
        .evicted_job  (evicted_job),
        .evicted_page (evicted_page),
        .hit_total    (hit_total),
        .fault_total  (fault_total)
    );

endmodule

`default_nettype wire
